/* rtl/core/polyline_douglas_peucker_simplifier_top_defines.svh */
// assertion helpers for the polyline simplifier
`ifndef POLYLINE_DOUGLAS_PEUCKER_SIMPLIFIER_TOP_DEFINES_SVH
`define POLYLINE_DOUGLAS_PEUCKER_SIMPLIFIER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define DPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DPS_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define DPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/core/dps_pkg.sv */
package dps_pkg;

   localparam int COORD_BITS   = 24;
   localparam int MAX_POINTS   = 64;
   localparam int TOL_BITS     = 23;
   localparam int IDX_OUT_BITS = 6;

endpackage

/* rtl/core/dps_channels.sv */
interface dps_req_if #(parameter int COORD_BITS = dps_pkg::COORD_BITS);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] x_in;
   logic signed [COORD_BITS-1:0] y_in;
   logic                         last_in;

   modport source (output valid, x_in, y_in, last_in, input ready);
   modport sink   (input valid, x_in, y_in, last_in, output ready);
endinterface

interface dps_rsp_if #(parameter int COORD_BITS = dps_pkg::COORD_BITS);
   logic                                valid;
   logic                                ready;
   logic signed [COORD_BITS-1:0]        x_out;
   logic signed [COORD_BITS-1:0]        y_out;
   logic [dps_pkg::IDX_OUT_BITS-1:0]    source_index;
   logic                                last_out;
   logic                                overflow;

   modport source (output valid, x_out, y_out, source_index, last_out, overflow,
                   input ready);
   modport sink   (input valid, x_out, y_out, source_index, last_out, overflow,
                   output ready);
endinterface

interface dps_csr_if;
   logic                           valid;
   logic                           ready;
   logic [dps_pkg::TOL_BITS-1:0]   tolerance;

   modport source (output valid, tolerance, input ready);
   modport sink   (input valid, tolerance, output ready);
endinterface

/* rtl/core/dps_mul.sv */
`include "polyline_douglas_peucker_simplifier_top_defines.svh"

module dps_mul #(
   parameter int AW = 99,
   parameter int BW = 50
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [AW-1:0] a,
   input  logic [BW-1:0] b,
   output logic          done,
   output logic [AW-1:0] prod
);

   logic          busy_ff;
   logic          done_ff;
   logic [AW-1:0] acc_ff;
   logic [AW-1:0] a_ff;
   logic [BW-1:0] b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && b_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // shift-add, one multiplier bit per cycle, stops when the rest is zero
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         a_ff   <= a;
         b_ff   <= b;
      end else if (busy_ff && b_ff != '0) begin
         if (b_ff[0]) begin
            acc_ff <= acc_ff + a_ff;
         end
         a_ff <= a_ff << 1;
         b_ff <= b_ff >> 1;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

   `DPS_ASSERT_NOW(a_start_idle, clock, reset, start, !busy_ff && !done_ff, "start while busy")
   `DPS_ASSERT_NOW(a_done_idle, clock, reset, done_ff, !busy_ff, "done while busy")
   `DPS_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff, "done held")

endmodule

/* rtl/core/polyline_douglas_peucker_simplifier_top.sv */
// Douglas-Peucker polyline simplifier. Points are taken one per cycle into a
// local store of MAX_POINTS entries until a point marked last; points past
// capacity are dropped and every result of that run carries overflow. The
// block then stops taking points and simplifies with a stack of split ends,
// emitting the first point and then each kept point in ascending order, the
// final one with last_out. All distance work runs on one shift-add multiplier
// that retires one multiplier bit per cycle. Each interior point of a segment
// takes five multiplies plus the read, load and classify states; each segment
// adds three multiplies. Comparisons are exact. A finished point waits in an
// output register. No clearing pass is needed after reset.
`include "polyline_douglas_peucker_simplifier_top_defines.svh"

module polyline_douglas_peucker_simplifier_top #(
   parameter int COORD_BITS = dps_pkg::COORD_BITS,
   parameter int MAX_POINTS = dps_pkg::MAX_POINTS
) (
   input logic    clock,
   input logic    reset,
   dps_req_if.sink   req_if,
   dps_rsp_if.source rsp_if,
   dps_csr_if.sink   csr_if
);

   localparam int C    = COORD_BITS;
   localparam int DW   = C + 1;
   localparam int PW   = 2 * C + 3;
   localparam int LW   = 2 * C + 2;
   localparam int TW   = dps_pkg::TOL_BITS;
   localparam int TW2  = 2 * TW;
   localparam int CW   = (4 * C + 3 > 2 * C + 2 + TW2) ? 4 * C + 3 : 2 * C + 2 + TW2;
   localparam int MB   = (LW > TW) ? LW : TW;
   localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNTW = $clog2(MAX_POINTS + 1);
   localparam int OW   = dps_pkg::IDX_OUT_BITS;

   localparam logic [4:0] ST_LOAD    = 5'd0;
   localparam logic [4:0] ST_TOLSQ   = 5'd1;
   localparam logic [4:0] ST_E_RD    = 5'd2;
   localparam logic [4:0] ST_E_OUT   = 5'd3;
   localparam logic [4:0] ST_PUSH0   = 5'd4;
   localparam logic [4:0] ST_SEG_STK = 5'd5;
   localparam logic [4:0] ST_SEG_A   = 5'd6;
   localparam logic [4:0] ST_SEG_B   = 5'd7;
   localparam logic [4:0] ST_SEG_C   = 5'd8;
   localparam logic [4:0] ST_LEN1    = 5'd9;
   localparam logic [4:0] ST_LEN2    = 5'd10;
   localparam logic [4:0] ST_THR     = 5'd11;
   localparam logic [4:0] ST_PT_RD   = 5'd12;
   localparam logic [4:0] ST_PT_LD   = 5'd13;
   localparam logic [4:0] ST_DOT1    = 5'd14;
   localparam logic [4:0] ST_DOT2    = 5'd15;
   localparam logic [4:0] ST_CLS     = 5'd16;
   localparam logic [4:0] ST_N1      = 5'd17;
   localparam logic [4:0] ST_N2      = 5'd18;
   localparam logic [4:0] ST_SC      = 5'd19;
   localparam logic [4:0] ST_DECIDE  = 5'd20;
   localparam logic [4:0] ST_POP     = 5'd21;
   localparam logic [4:0] ST_DONE    = 5'd22;

   localparam logic [1:0] MODE_NEAR_A = 2'd0;
   localparam logic [1:0] MODE_NEAR_B = 2'd1;
   localparam logic [1:0] MODE_CROSS  = 2'd2;

   function automatic logic [DW-1:0] mag_dw(input logic signed [DW-1:0] v);
      mag_dw = v[DW-1] ? DW'(-v) : DW'(v);
   endfunction

   function automatic logic [PW-1:0] mag_pw(input logic signed [PW-1:0] v);
      mag_pw = v[PW-1] ? PW'(-v) : PW'(v);
   endfunction

   // state
   logic [4:0]              state_ff;
   logic [CNTW-1:0]         count_ff;
   logic [CNTW-1:0]         top_ff;
   logic [IW-1:0]           anchor_ff;
   logic [IW-1:0]           seg_end_ff;
   logic [IW-1:0]           k_ff;
   logic [IW-1:0]           best_k_ff;
   logic                    found_ff;
   logic                    overflow_ff;
   logic                    issued_ff;
   logic [TW-1:0]           tol_ff;
   logic [TW2-1:0]          tol2_ff;
   logic [IW-1:0]           emit_idx_ff;
   logic                    emit_first_ff;
   logic                    emit_last_ff;
   logic [1:0]              mode_ff;

   // geometry
   logic signed [C-1:0]     ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [DW-1:0]    dxab_ff, dyab_ff, dxp_ff, dyp_ff, dxq_ff, dyq_ff;
   logic signed [PW-1:0]    r_ff, dot_ff;
   logic [LW-1:0]           len_ff;
   logic [LW-1:0]           lenp;
   logic [CW-1:0]           thr_ff, best_ff;

   // memories
   logic [2*C-1:0]          point_mem_ff [MAX_POINTS];
   logic [2*C-1:0]          pt_rd_ff;
   logic [IW-1:0]           pt_raddr;
   logic                    pt_we;
   logic [IW-1:0]           stack_mem_ff [MAX_POINTS];
   logic [IW-1:0]           stk_rd_ff;
   logic [IW-1:0]           stk_raddr;
   logic                    stk_we;
   logic [IW-1:0]           stk_waddr;
   logic [IW-1:0]           stk_wdata;

   // output register
   logic                    rsp_valid_ff;
   logic signed [C-1:0]     x_out_ff, y_out_ff;
   logic [OW-1:0]           idx_out_ff;
   logic                    last_out_ff;
   logic                    ovf_out_ff;

   // multiplier
   logic                    is_mul;
   logic                    mul_start;
   logic                    mul_done;
   logic [CW-1:0]           mul_a;
   logic [MB-1:0]           mul_b;
   logic                    mul_neg;
   logic [CW-1:0]           mul_prod;
   logic signed [PW-1:0]    prod_pw;
   logic signed [PW-1:0]    prod_s;
   logic [PW-1:0]           r_mag;
   logic                    step_done;

   logic signed [C-1:0]     rd_x, rd_y;
   logic                    req_take;
   logic                    rsp_take;
   logic                    out_load;

   assign rd_x = pt_rd_ff[C-1:0];
   assign rd_y = pt_rd_ff[2*C-1:C];
   assign lenp = (len_ff == '0) ? LW'(1) : len_ff;
   assign r_mag = mag_pw(r_ff);

   assign req_take = req_if.valid && req_if.ready;
   assign rsp_take = rsp_valid_ff && rsp_if.ready;
   assign out_load = (state_ff == ST_E_OUT) && !rsp_valid_ff;

   assign req_if.ready = (state_ff == ST_LOAD);
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.x_out        = x_out_ff;
   assign rsp_if.y_out        = y_out_ff;
   assign rsp_if.source_index = idx_out_ff;
   assign rsp_if.last_out     = last_out_ff;
   assign rsp_if.overflow     = ovf_out_ff;

   assign is_mul = state_ff inside {ST_TOLSQ, ST_LEN1, ST_LEN2, ST_THR, ST_DOT1, ST_DOT2,
                                    ST_N1, ST_N2, ST_SC};
   assign mul_start = is_mul && !issued_ff;
   assign step_done = is_mul && issued_ff && mul_done;
   assign prod_pw   = mul_prod[PW-1:0];
   assign prod_s    = mul_neg ? -prod_pw : prod_pw;

   // operand select for the shared multiplier
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      case (state_ff)
         ST_TOLSQ: begin
            mul_a = CW'(tol_ff);
            mul_b = MB'(tol_ff);
         end
         ST_LEN1: begin
            mul_a = CW'(mag_dw(dxab_ff));
            mul_b = MB'(mag_dw(dxab_ff));
         end
         ST_LEN2: begin
            mul_a = CW'(mag_dw(dyab_ff));
            mul_b = MB'(mag_dw(dyab_ff));
         end
         ST_THR: begin
            mul_a = CW'(tol2_ff);
            mul_b = MB'(lenp);
         end
         ST_DOT1: begin
            mul_a   = CW'(mag_dw(dxp_ff));
            mul_b   = MB'(mag_dw(dxab_ff));
            mul_neg = dxp_ff[DW-1] ^ dxab_ff[DW-1];
         end
         ST_DOT2: begin
            mul_a   = CW'(mag_dw(dyp_ff));
            mul_b   = MB'(mag_dw(dyab_ff));
            mul_neg = dyp_ff[DW-1] ^ dyab_ff[DW-1];
         end
         ST_N1: begin
            case (mode_ff)
               MODE_NEAR_A: begin
                  mul_a = CW'(mag_dw(dxp_ff));
                  mul_b = MB'(mag_dw(dxp_ff));
               end
               MODE_NEAR_B: begin
                  mul_a = CW'(mag_dw(dxq_ff));
                  mul_b = MB'(mag_dw(dxq_ff));
               end
               default: begin
                  mul_a   = CW'(mag_dw(dxp_ff));
                  mul_b   = MB'(mag_dw(dyab_ff));
                  mul_neg = dxp_ff[DW-1] ^ dyab_ff[DW-1];
               end
            endcase
         end
         ST_N2: begin
            case (mode_ff)
               MODE_NEAR_A: begin
                  mul_a = CW'(mag_dw(dyp_ff));
                  mul_b = MB'(mag_dw(dyp_ff));
               end
               MODE_NEAR_B: begin
                  mul_a = CW'(mag_dw(dyq_ff));
                  mul_b = MB'(mag_dw(dyq_ff));
               end
               default: begin
                  mul_a   = CW'(mag_dw(dyp_ff));
                  mul_b   = MB'(mag_dw(dxab_ff));
                  mul_neg = !(dyp_ff[DW-1] ^ dxab_ff[DW-1]);
               end
            endcase
         end
         ST_SC: begin
            mul_a = CW'(r_mag);
            mul_b = (mode_ff == MODE_CROSS) ? MB'(r_mag) : MB'(lenp);
         end
         default: begin
            mul_a   = '0;
            mul_b   = '0;
            mul_neg = 1'b0;
         end
      endcase
   end

   dps_mul #(
      .AW (CW),
      .BW (MB)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   // memory addressing
   always_comb begin
      case (state_ff)
         ST_E_RD, ST_E_OUT: pt_raddr = emit_idx_ff;
         ST_SEG_A:          pt_raddr = anchor_ff;
         ST_SEG_B:          pt_raddr = seg_end_ff;
         default:           pt_raddr = k_ff;
      endcase
   end

   assign pt_we     = req_take && (count_ff < CNTW'(MAX_POINTS));
   assign stk_raddr = IW'(top_ff - CNTW'(1));

   always_comb begin
      stk_we    = 1'b0;
      stk_waddr = IW'(top_ff);
      stk_wdata = best_k_ff;
      case (state_ff)
         ST_PUSH0: begin
            stk_we    = 1'b1;
            stk_wdata = IW'(count_ff - CNTW'(1));
         end
         ST_DECIDE: begin
            stk_we = (best_ff > thr_ff) && (top_ff < CNTW'(MAX_POINTS));
         end
         default: begin
            stk_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pt_we) begin
         point_mem_ff[IW'(count_ff)] <= {req_if.y_in, req_if.x_in};
      end
      pt_rd_ff <= point_mem_ff[pt_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem_ff[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= stack_mem_ff[stk_raddr];
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_if.valid) begin
         tol_ff <= csr_if.tolerance;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         x_out_ff    <= rd_x;
         y_out_ff    <= rd_y;
         idx_out_ff  <= OW'(emit_idx_ff);
         last_out_ff <= emit_last_ff;
         ovf_out_ff  <= overflow_ff;
      end
   end

   // sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         count_ff    <= '0;
         top_ff      <= '0;
         anchor_ff   <= '0;
         overflow_ff <= 1'b0;
         issued_ff   <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         if (mul_start) begin
            issued_ff <= 1'b1;
         end else if (step_done) begin
            issued_ff <= 1'b0;
         end
         case (state_ff)
            ST_LOAD: begin
               if (req_take) begin
                  if (count_ff < CNTW'(MAX_POINTS)) begin
                     count_ff <= count_ff + CNTW'(1);
                  end else begin
                     overflow_ff <= 1'b1;
                  end
                  if (req_if.last_in) begin
                     state_ff <= ST_TOLSQ;
                  end
               end
            end
            ST_TOLSQ: begin
               if (step_done) begin
                  state_ff <= ST_E_RD;
               end
            end
            ST_E_RD: begin
               state_ff <= ST_E_OUT;
            end
            ST_E_OUT: begin
               if (!rsp_valid_ff) begin
                  if (emit_last_ff) begin
                     state_ff <= ST_DONE;
                  end else if (emit_first_ff) begin
                     state_ff <= ST_PUSH0;
                  end else begin
                     state_ff <= ST_SEG_STK;
                  end
               end
            end
            ST_PUSH0: begin
               top_ff    <= CNTW'(1);
               anchor_ff <= '0;
               state_ff  <= ST_SEG_STK;
            end
            ST_SEG_STK: state_ff <= ST_SEG_A;
            ST_SEG_A:   state_ff <= ST_SEG_B;
            ST_SEG_B:   state_ff <= ST_SEG_C;
            ST_SEG_C: begin
               if (CNTW'(anchor_ff) + CNTW'(1) >= CNTW'(seg_end_ff)) begin
                  state_ff <= ST_POP;
               end else begin
                  state_ff <= ST_LEN1;
               end
            end
            ST_LEN1: begin
               if (step_done) begin
                  state_ff <= ST_LEN2;
               end
            end
            ST_LEN2: begin
               if (step_done) begin
                  state_ff <= ST_THR;
               end
            end
            ST_THR: begin
               if (step_done) begin
                  found_ff <= 1'b0;
                  state_ff <= ST_PT_RD;
               end
            end
            ST_PT_RD: state_ff <= ST_PT_LD;
            ST_PT_LD: state_ff <= ST_DOT1;
            ST_DOT1: begin
               if (step_done) begin
                  state_ff <= ST_DOT2;
               end
            end
            ST_DOT2: begin
               if (step_done) begin
                  state_ff <= ST_CLS;
               end
            end
            ST_CLS: state_ff <= ST_N1;
            ST_N1: begin
               if (step_done) begin
                  state_ff <= ST_N2;
               end
            end
            ST_N2: begin
               if (step_done) begin
                  state_ff <= ST_SC;
               end
            end
            ST_SC: begin
               if (step_done) begin
                  found_ff <= 1'b1;
                  if (CNTW'(k_ff) + CNTW'(1) < CNTW'(seg_end_ff)) begin
                     state_ff <= ST_PT_RD;
                  end else begin
                     state_ff <= ST_DECIDE;
                  end
               end
            end
            ST_DECIDE: begin
               if (stk_we) begin
                  top_ff   <= top_ff + CNTW'(1);
                  state_ff <= ST_SEG_STK;
               end else begin
                  state_ff <= ST_POP;
               end
            end
            ST_POP: begin
               anchor_ff <= seg_end_ff;
               top_ff    <= top_ff - CNTW'(1);
               state_ff  <= ST_E_RD;
            end
            ST_DONE: begin
               count_ff    <= '0;
               top_ff      <= '0;
               anchor_ff   <= '0;
               overflow_ff <= 1'b0;
               state_ff    <= ST_LOAD;
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_TOLSQ: begin
            if (step_done) begin
               tol2_ff       <= mul_prod[TW2-1:0];
               emit_idx_ff   <= '0;
               emit_first_ff <= 1'b1;
               emit_last_ff  <= 1'b0;
            end
         end
         ST_SEG_A: begin
            seg_end_ff <= stk_rd_ff;
         end
         ST_SEG_B: begin
            ax_ff <= rd_x;
            ay_ff <= rd_y;
         end
         ST_SEG_C: begin
            bx_ff   <= rd_x;
            by_ff   <= rd_y;
            dxab_ff <= DW'(rd_x) - DW'(ax_ff);
            dyab_ff <= DW'(rd_y) - DW'(ay_ff);
         end
         ST_LEN1: begin
            if (step_done) begin
               r_ff <= prod_s;
            end
         end
         ST_LEN2: begin
            if (step_done) begin
               len_ff <= LW'(r_ff + prod_s);
            end
         end
         ST_THR: begin
            if (step_done) begin
               thr_ff <= mul_prod;
               k_ff   <= anchor_ff + IW'(1);
            end
         end
         ST_PT_LD: begin
            dxp_ff <= DW'(rd_x) - DW'(ax_ff);
            dyp_ff <= DW'(rd_y) - DW'(ay_ff);
            dxq_ff <= DW'(rd_x) - DW'(bx_ff);
            dyq_ff <= DW'(rd_y) - DW'(by_ff);
         end
         ST_DOT1: begin
            if (step_done) begin
               r_ff <= prod_s;
            end
         end
         ST_DOT2: begin
            if (step_done) begin
               dot_ff <= r_ff + prod_s;
            end
         end
         ST_CLS: begin
            // projection before the anchor, past the end, or onto the segment
            if (len_ff == '0 || dot_ff <= 0) begin
               mode_ff <= MODE_NEAR_A;
            end else if (PW'(unsigned'(dot_ff)) >= PW'(len_ff)) begin
               mode_ff <= MODE_NEAR_B;
            end else begin
               mode_ff <= MODE_CROSS;
            end
         end
         ST_N1: begin
            if (step_done) begin
               r_ff <= prod_s;
            end
         end
         ST_N2: begin
            if (step_done) begin
               r_ff <= r_ff + prod_s;
            end
         end
         ST_SC: begin
            // every candidate is scaled to the common denominator len2
            if (step_done) begin
               if (!found_ff || mul_prod > best_ff) begin
                  best_ff   <= mul_prod;
                  best_k_ff <= k_ff;
               end
               k_ff <= k_ff + IW'(1);
            end
         end
         ST_POP: begin
            emit_idx_ff   <= seg_end_ff;
            emit_first_ff <= 1'b0;
            emit_last_ff  <= (top_ff == CNTW'(1));
         end
         default: begin
         end
      endcase
   end

   `DPS_ASSERT_NOW(a_stack_bound, clock, reset, 1'b1, top_ff <= CNTW'(MAX_POINTS), "stack overrun")
   `DPS_ASSERT_NOW(a_seg_order, clock, reset, state_ff == ST_LEN1, anchor_ff < seg_end_ff, "bad segment")
   `DPS_ASSERT_NOW(a_scan_range, clock, reset, state_ff == ST_PT_RD, (k_ff > anchor_ff) && (k_ff < seg_end_ff), "scan out of segment")
   `DPS_ASSERT_NEXT(a_load_hold, clock, reset, rsp_valid_ff && !rsp_if.ready, rsp_valid_ff && $stable(idx_out_ff), "result lost")

endmodule
